// ===== src/posl_pkg.sv =====
// posl_pkg: shared constants, codes and types of the priority ordered slot list.
// Used by posl_cell, posl_free_stack and priority_ordered_slot_list_core.
package posl_pkg;

	localparam int POOL_SIZE = 64;
	localparam int SLOT_W    = 6;
	localparam int PRIO_W    = 8;
	localparam int TOP_W     = 7;
	localparam int CNT_W     = 6;

	localparam logic [2:0] OP_ADD        = 3'd0;
	localparam logic [2:0] OP_REMOVE     = 3'd1;
	localparam logic [2:0] OP_SET_PRIO   = 3'd2;
	localparam logic [2:0] OP_REMOVE_ALL = 3'd3;
	localparam logic [2:0] OP_WALK       = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOT_USED = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_MARK,
		CELL_COMPACT,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [SLOT_W-1:0] slot;
		logic [PRIO_W-1:0] key;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_INSERT,
		S_MARK,
		S_COMPACT,
		S_CLEAR,
		S_WALK,
		S_EMIT
	} state_t;

endpackage

// ===== src/posl_cell.sv =====
// posl_cell: one position of the ordered list chain.
// Depends on posl_pkg for entry and command types.
module posl_cell import posl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  entry_t    left_e,
	input  logic      left_hole,
	input  entry_t    right_e,
	output entry_t    own_e,
	output logic      hole
);

	logic              valid_q;
	logic              hole_q;
	logic [SLOT_W-1:0] slot_q;
	logic [PRIO_W-1:0] prio_q;

	logic   load;
	logic   hole_d;
	entry_t load_e;

	always_comb begin
		load   = 1'b0;
		hole_d = hole_q;
		load_e = right_e;
		case (cmd.op)
			CELL_INSERT: begin
				if (left_e.valid && left_e.prio > cmd.key) begin
					load   = 1'b1;
					load_e = left_e;
				end else if ((!valid_q || prio_q > cmd.key) && left_e.valid) begin
					load   = 1'b1;
					load_e = '{valid: 1'b1, slot: cmd.slot, prio: cmd.key};
				end
			end
			CELL_MARK: begin
				hole_d = valid_q && (slot_q == cmd.slot);
			end
			CELL_COMPACT: begin
				if (hole_q) begin
					load   = 1'b1;
					hole_d = 1'b0;
				end else if (left_hole && valid_q) begin
					hole_d = 1'b1;
				end
			end
			CELL_SHIFT: begin
				load = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hole_q  <= 1'b0;
		end else begin
			hole_q <= hole_d;
			if (load) valid_q <= load_e.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= load_e.slot;
			prio_q <= load_e.prio;
		end
	end

	assign own_e = '{valid: valid_q, slot: slot_q, prio: prio_q};
	assign hole  = hole_q;

endmodule

// ===== src/posl_free_stack.sv =====
// posl_free_stack: last-in-first-out stack of free slot numbers.
// Depends on posl_pkg; positions at or above the high-water mark read as their own index.
module posl_free_stack import posl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop,
	input  logic              push,
	input  logic [SLOT_W-1:0] push_slot,
	output logic [SLOT_W-1:0] top_slot,
	output logic [TOP_W-1:0]  free_top,
	output logic              full
);

	logic [SLOT_W-1:0] mem [POOL_SIZE];
	logic [TOP_W-1:0]  top_q;
	logic [TOP_W-1:0]  hw_q;
	logic [SLOT_W-1:0] rd_q;
	logic [SLOT_W-1:0] idx_q;
	logic              byp_q;
	logic [TOP_W-1:0]  top_dec;
	logic [TOP_W-1:0]  top_inc;

	assign top_dec = top_q - TOP_W'(1);
	assign top_inc = top_q + TOP_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			hw_q  <= '0;
		end else if (pop) begin
			top_q <= top_inc;
			if (top_inc > hw_q) hw_q <= top_inc;
		end else if (push && top_q != '0) begin
			top_q <= top_dec;
		end
	end

	// write at the slot below top; registered read at top
	always_ff @(posedge clk) begin
		if (push && !pop && top_q != '0) mem[top_dec[SLOT_W-1:0]] <= push_slot;
		rd_q  <= mem[top_q[SLOT_W-1:0]];
		idx_q <= top_q[SLOT_W-1:0];
		byp_q <= (top_q >= hw_q);
	end

	assign top_slot = byp_q ? idx_q : rd_q;
	assign free_top = top_q;
	assign full     = (top_q >= TOP_W'(POOL_SIZE));

endmodule

// ===== src/priority_ordered_slot_list_core.sv =====
// priority_ordered_slot_list_core: top level, sequencer around a chain of list cells.
// Depends on posl_pkg, posl_cell and posl_free_stack.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-------------------------------------------
//   in      | in        | in_valid / in_stall  | operation, slot, priority_req
//   out     | out       | out_valid / out_stall| result_slot, result_priority, status, last
//   cfg     | in        | cfg_valid / cfg_ready| walk_enabled
//
// Steps: add pops a free slot and inserts it; remove and set_priority mark the slot
// and walk the hole through the 64-cell chain, set_priority then inserting anew;
// remove_all shifts out each listed entry; walk rotates the chain once, held by output stalls.
// One word is worked on at a time; in_stall is high outside the idle state.
// A result waiting in the output register does not block the next input word.
// Reset is asynchronous; the chain resets empty and no clearing pass is needed.
module priority_ordered_slot_list_core import posl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        operation,
	input  logic [SLOT_W-1:0] slot,
	input  logic [PRIO_W-1:0] priority_req,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SLOT_W-1:0] result_slot,
	output logic [PRIO_W-1:0] result_priority,
	output logic [1:0]        status,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              walk_enabled
);

	localparam entry_t HEAD_ENTRY = '{valid: 1'b1, slot: '0, prio: '0};

	state_t state_q, state_d;

	logic [2:0]        op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [PRIO_W-1:0] prio_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              walk_en_q;
	logic              in_list_q [POOL_SIZE];
	logic              lst_rd_q;
	logic [PRIO_W-1:0] prio_mem [POOL_SIZE];
	logic [PRIO_W-1:0] pm_rd_q;

	logic [SLOT_W-1:0] em_slot_q;
	logic [PRIO_W-1:0] em_prio_q;
	logic [1:0]        em_status_q;

	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [PRIO_W-1:0] out_prio_q;
	logic [1:0]        out_status_q;
	logic              out_last_q;

	// chain
	entry_t    cell_e [POOL_SIZE];
	logic      cell_hole [POOL_SIZE];
	entry_t    tail_in;
	logic      wrap;
	cell_cmd_t cmd;

	// free stack
	logic              fs_pop, fs_push, fs_full;
	logic [SLOT_W-1:0] fs_push_slot, fs_top_slot;
	logic [TOP_W-1:0]  fs_top;

	// sequencer outputs
	logic              accept;
	logic              out_free;
	logic              emit;
	logic [SLOT_W-1:0] emit_slot;
	logic [PRIO_W-1:0] emit_prio;
	logic [1:0]        emit_status;
	logic              emit_last;
	logic              em_load;
	logic [SLOT_W-1:0] em_slot_d;
	logic [PRIO_W-1:0] em_prio_d;
	logic [1:0]        em_status_d;
	logic              slot_load;
	logic              cnt_clr, cnt_inc;
	logic              list_set, list_clr;
	logic [SLOT_W-1:0] list_clr_idx;
	logic              pm_we;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// the chain: cell 0 heads the list, each cell talks only to its neighbors and the tail wraps to cell 0
	assign tail_in = wrap ? cell_e[0] : '0;

	for (genvar i = 0; i < POOL_SIZE; i++) begin : g_cell
		entry_t left_e, right_e;
		logic   left_hole;
		if (i == 0) begin : g_head
			assign left_e    = HEAD_ENTRY;
			assign left_hole = 1'b0;
		end else begin : g_body
			assign left_e    = cell_e[i-1];
			assign left_hole = cell_hole[i-1];
		end
		if (i == POOL_SIZE - 1) begin : g_tail
			assign right_e = tail_in;
		end else begin : g_mid
			assign right_e = cell_e[i+1];
		end
		posl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left_e    (left_e),
			.left_hole (left_hole),
			.right_e   (right_e),
			.own_e     (cell_e[i]),
			.hole      (cell_hole[i])
		);
	end

	posl_free_stack u_free_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (fs_pop),
		.push      (fs_push),
		.push_slot (fs_push_slot),
		.top_slot  (fs_top_slot),
		.free_top  (fs_top),
		.full      (fs_full)
	);

	// sequencer
	always_comb begin
		state_d      = state_q;
		cmd          = '{op: CELL_HOLD, slot: slot_q, key: prio_q};
		wrap         = 1'b0;
		fs_pop       = 1'b0;
		fs_push      = 1'b0;
		fs_push_slot = slot_q;
		emit         = 1'b0;
		emit_slot    = em_slot_q;
		emit_prio    = em_prio_q;
		emit_status  = em_status_q;
		emit_last    = 1'b1;
		em_load      = 1'b0;
		em_slot_d    = '0;
		em_prio_d    = '0;
		em_status_d  = ST_OK;
		slot_load    = 1'b0;
		cnt_clr      = 1'b0;
		cnt_inc      = 1'b0;
		list_set     = 1'b0;
		list_clr     = 1'b0;
		list_clr_idx = slot_q;
		pm_we        = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (operation) inside
						OP_ADD: begin
							if (fs_full) begin
								em_load     = 1'b1;
								em_status_d = ST_FULL;
								state_d     = S_EMIT;
							end else begin
								state_d = S_POP;
							end
						end
						// the in-list flag of the slot is read into lst_rd_q at this edge
						OP_REMOVE, OP_SET_PRIO: state_d = S_MARK;
						OP_REMOVE_ALL: state_d = S_CLEAR;
						OP_WALK: begin
							if (!walk_en_q || !cell_e[0].valid) begin
								em_load     = 1'b1;
								em_status_d = ST_EMPTY;
								state_d     = S_EMIT;
							end else begin
								cnt_clr = 1'b1;
								state_d = S_WALK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_POP: begin
				// take the slot on top of the free stack
				fs_pop    = 1'b1;
				slot_load = 1'b1;
				state_d   = S_INSERT;
			end
			S_INSERT: begin
				if (out_free) begin
					cmd         = '{op: CELL_INSERT, slot: slot_q, key: prio_q};
					pm_we       = 1'b1;
					list_set    = 1'b1;
					emit        = 1'b1;
					emit_slot   = slot_q;
					emit_prio   = prio_q;
					emit_status = ST_OK;
					state_d     = S_IDLE;
				end
			end
			S_MARK: begin
				if (!lst_rd_q) begin
					// slot not in use: report it and change nothing
					em_load     = 1'b1;
					em_slot_d   = slot_q;
					em_status_d = ST_NOT_USED;
					state_d     = S_EMIT;
				end else begin
					cmd     = '{op: CELL_MARK, slot: slot_q, key: prio_q};
					cnt_clr = 1'b1;
					if (op_q == OP_REMOVE) begin
						fs_push   = 1'b1;
						list_clr  = 1'b1;
						em_load   = 1'b1;
						em_slot_d = slot_q;
						em_prio_d = pm_rd_q;
					end
					state_d = S_COMPACT;
				end
			end
			S_COMPACT: begin
				// walk the hole to the tail, one cell a cycle
				cmd     = '{op: CELL_COMPACT, slot: slot_q, key: prio_q};
				cnt_inc = 1'b1;
				if (cnt_q == CNT_W'(POOL_SIZE - 1)) begin
					state_d = (op_q == OP_REMOVE) ? S_EMIT : S_INSERT;
				end
			end
			S_CLEAR: begin
				if (cell_e[0].valid) begin
					cmd          = '{op: CELL_SHIFT, slot: slot_q, key: prio_q};
					fs_push      = 1'b1;
					fs_push_slot = cell_e[0].slot;
					list_clr     = 1'b1;
					list_clr_idx = cell_e[0].slot;
				end else begin
					em_load = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_WALK: begin
				// rotate the whole chain once; list it as it passes cell 0
				if (!cell_e[0].valid || out_free) begin
					cmd         = '{op: CELL_SHIFT, slot: slot_q, key: prio_q};
					wrap        = 1'b1;
					cnt_inc     = 1'b1;
					emit        = cell_e[0].valid;
					emit_slot   = cell_e[0].slot;
					emit_prio   = cell_e[0].prio;
					emit_status = ST_OK;
					emit_last   = !cell_e[1].valid || (cnt_q == CNT_W'(POOL_SIZE - 1));
					if (cnt_q == CNT_W'(POOL_SIZE - 1)) state_d = S_IDLE;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			walk_en_q <= 1'b1;
			cnt_q     <= '0;
			for (int i = 0; i < POOL_SIZE; i++) in_list_q[i] <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) walk_en_q <= walk_enabled;
			if (cnt_clr) cnt_q <= '0;
			else if (cnt_inc) cnt_q <= cnt_q + CNT_W'(1);
			if (list_set) in_list_q[slot_q] <= 1'b1;
			if (list_clr) in_list_q[list_clr_idx] <= 1'b0;
			if (emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			slot_q <= slot;
			prio_q <= priority_req;
		end else if (slot_load) begin
			slot_q <= fs_top_slot;
		end
		if (em_load) begin
			em_slot_q   <= em_slot_d;
			em_prio_q   <= em_prio_d;
			em_status_q <= em_status_d;
		end
		if (emit) begin
			out_slot_q   <= emit_slot;
			out_prio_q   <= emit_prio;
			out_status_q <= emit_status;
			out_last_q   <= emit_last;
		end
	end

	// priority and in-list flag per slot, read at the addressed slot
	always_ff @(posedge clk) begin
		if (pm_we) prio_mem[slot_q] <= prio_q;
		pm_rd_q  <= prio_mem[slot];
		lst_rd_q <= in_list_q[slot];
	end

	assign out_valid       = out_valid_q;
	assign result_slot     = out_slot_q;
	assign result_priority = out_prio_q;
	assign status          = out_status_q;
	assign last            = out_last_q;

	// the free stack never runs past the pool
	a_top_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fs_top <= TOP_W'(POOL_SIZE))
		else $error("free stack top beyond pool");

	// at rest the chain head is occupied exactly when some slot is taken
	a_head_matches_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (cell_e[0].valid == (fs_top != '0)))
		else $error("chain head disagrees with free stack");

	// a newly taken slot is never already listed
	a_popped_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INSERT && op_q == OP_ADD) |-> !in_list_q[slot_q])
		else $error("allocated slot already in list");

endmodule

// ===== bench/priority_ordered_slot_list_core_test.sv =====
// priority_ordered_slot_list_core_test: self-checking bench for the priority ordered slot list.
// Depends on posl_pkg and priority_ordered_slot_list_core; holds its own list predictor.
module priority_ordered_slot_list_core_test;
	import posl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [6:0] NO_SLOT = 7'd64;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 200;

	typedef struct {
		logic [SLOT_W-1:0] slot;
		logic [PRIO_W-1:0] prio;
		logic [1:0]        status;
		logic              last;
	} result_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [2:0]        operation;
	logic [SLOT_W-1:0] slot;
	logic [PRIO_W-1:0] priority_req;
	logic              out_valid;
	logic              out_stall;
	logic [SLOT_W-1:0] result_slot;
	logic [PRIO_W-1:0] result_priority;
	logic [1:0]        status;
	logic              last;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              walk_enabled;

	// list predictor state
	logic [PRIO_W-1:0] key_of [POOL_SIZE];
	logic [6:0]        next_of [POOL_SIZE];
	logic [6:0]        prev_of [POOL_SIZE];
	logic              linked [POOL_SIZE];
	logic [SLOT_W-1:0] spare [POOL_SIZE];
	int                taken;
	logic [6:0]        head;
	logic [6:0]        tail;
	logic              listing_on;

	result_t expected_results[$];
	int      errors;
	int      words_sent;
	int      results_seen;
	int      walks_sent;
	int      cycles;
	bit      quiet;
	int      hold_left;
	int      burst_left;

	priority_ordered_slot_list_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .slot(slot), .priority_req(priority_req),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_slot(result_slot), .result_priority(result_priority),
		.status(status), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .walk_enabled(walk_enabled)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cycles,
				expected_results.size());
			$display("priority_ordered_slot_list_core_test NOT OK");
			$finish;
		end
	end

	// Receiver: random stall bursts, a long hold-off on request, none when quiet.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (burst_left > 0) begin
			out_stall <= 1'b1;
			burst_left <= burst_left - 1;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			burst_left <= $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare every accepted result word with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				errors <= errors + 1;
				$display("%0t: unexpected result slot=%0d prio=%0d status=%0d last=%0d", $time,
					result_slot, result_priority, status, last);
			end else begin
				want = expected_results.pop_front();
				if (result_slot !== want.slot || result_priority !== want.prio ||
					status !== want.status || last !== want.last) begin
					errors <= errors + 1;
					$display("%0t: mismatch expected slot=%0d prio=%0d status=%0d last=%0d",
						$time, want.slot, want.prio, want.status, want.last);
					$display("%0t:          actual   slot=%0d prio=%0d status=%0d last=%0d",
						$time, result_slot, result_priority, status, last);
				end
			end
		end
	end

	function automatic void expect_word(logic [SLOT_W-1:0] s, logic [PRIO_W-1:0] p,
		logic [1:0] st, logic l);
		result_t r;
		r.slot = s;
		r.prio = p;
		r.status = st;
		r.last = l;
		expected_results.push_back(r);
	endfunction

	// Link a slot in after every entry of equal or lower key.
	function automatic void link_slot(logic [5:0] s);
		logic [6:0] cur;
		logic [6:0] ahead;
		if (head == NO_SLOT) begin
			head = {1'b0, s};
			tail = {1'b0, s};
			prev_of[s] = NO_SLOT;
			next_of[s] = NO_SLOT;
			return;
		end
		if (key_of[tail[5:0]] <= key_of[s]) begin
			prev_of[s] = tail;
			next_of[tail[5:0]] = {1'b0, s};
			next_of[s] = NO_SLOT;
			tail = {1'b0, s};
			return;
		end
		cur = head;
		while (cur != NO_SLOT) begin
			if (key_of[cur[5:0]] > key_of[s]) begin
				ahead = prev_of[cur[5:0]];
				if (ahead != NO_SLOT) next_of[ahead[5:0]] = {1'b0, s};
				else head = {1'b0, s};
				prev_of[s] = ahead;
				prev_of[cur[5:0]] = {1'b0, s};
				next_of[s] = cur;
				return;
			end
			cur = next_of[cur[5:0]];
		end
	endfunction

	function automatic void unlink_slot(logic [5:0] s);
		logic [6:0] pv;
		logic [6:0] nx;
		pv = prev_of[s];
		nx = next_of[s];
		if (pv != NO_SLOT) next_of[pv[5:0]] = nx; else head = nx;
		if (nx != NO_SLOT) prev_of[nx[5:0]] = pv; else tail = pv;
	endfunction

	function automatic void release_slot(logic [5:0] s);
		unlink_slot(s);
		linked[s] = 1'b0;
		if (taken > 0) begin
			taken--;
			spare[taken] = s;
		end
	endfunction

	// Advance the list state by one input word and queue the results it causes.
	function automatic void predict_list(logic [2:0] op, logic [5:0] s, logic [7:0] p);
		logic [5:0] n;
		logic [6:0] cur;
		logic [6:0] nx;
		logic [7:0] old;
		int k;
		case (op)
			OP_ADD: begin
				if (taken >= POOL_SIZE) begin
					expect_word('0, '0, ST_FULL, 1'b1);
				end else begin
					n = spare[taken];
					taken++;
					key_of[n] = p;
					linked[n] = 1'b1;
					link_slot(n);
					expect_word(n, p, ST_OK, 1'b1);
				end
			end
			OP_REMOVE: begin
				if (!linked[s]) begin
					expect_word(s, '0, ST_NOT_USED, 1'b1);
				end else begin
					old = key_of[s];
					release_slot(s);
					expect_word(s, old, ST_OK, 1'b1);
				end
			end
			OP_SET_PRIO: begin
				if (!linked[s]) begin
					expect_word(s, '0, ST_NOT_USED, 1'b1);
				end else begin
					unlink_slot(s);
					key_of[s] = p;
					link_slot(s);
					expect_word(s, p, ST_OK, 1'b1);
				end
			end
			OP_REMOVE_ALL: begin
				cur = head;
				k = 0;
				while (cur != NO_SLOT && k < POOL_SIZE) begin
					nx = next_of[cur[5:0]];
					release_slot(cur[5:0]);
					cur = nx;
					k++;
				end
				expect_word('0, '0, ST_OK, 1'b1);
			end
			OP_WALK: begin
				if (!listing_on || head == NO_SLOT) begin
					expect_word('0, '0, ST_EMPTY, 1'b1);
				end else begin
					cur = head;
					k = 0;
					while (cur != NO_SLOT && k < POOL_SIZE) begin
						nx = next_of[cur[5:0]];
						expect_word(cur[5:0], key_of[cur[5:0]], ST_OK,
							nx == NO_SLOT || k == POOL_SIZE - 1);
						k++;
						cur = nx;
					end
				end
			end
			default: ;
		endcase
	endfunction

	// Offer one word, hold it until accepted, then predict. Leaves in_valid high.
	task automatic send_word(logic [2:0] op, logic [5:0] s, logic [7:0] p);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		slot <= s;
		priority_req <= p;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		predict_list(op, s, p);
		words_sent++;
		if (op == OP_WALK) walks_sent++;
	endtask

	// Drop valid, wait for every expected result, then let any ignored word finish.
	task automatic drain;
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_walk_enabled(logic v);
		drain();
		cfg_valid <= 1'b1;
		walk_enabled <= v;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		listing_on = v;
	endtask

	// Pick a live slot most of the time so remove and set_priority do real work.
	function automatic logic [5:0] pick_slot();
		logic [5:0] s;
		int tries;
		s = SLOT_W'($urandom_range(0, POOL_SIZE - 1));
		if ($urandom_range(0, 9) < 8 && taken > 0)
			for (tries = 0; tries < 200 && !linked[s]; tries++)
				s = SLOT_W'($urandom_range(0, POOL_SIZE - 1));
		return s;
	endfunction

	task automatic send_random_word;
		int dice;
		dice = $urandom_range(0, 99);
		if (dice < 38) send_word(OP_ADD, SLOT_W'($urandom), PRIO_W'($urandom));
		else if (dice < 58) send_word(OP_REMOVE, pick_slot(), PRIO_W'($urandom));
		else if (dice < 80) send_word(OP_SET_PRIO, pick_slot(), PRIO_W'($urandom));
		else if (dice < 93) send_word(OP_WALK, SLOT_W'($urandom), PRIO_W'($urandom));
		else if (dice < 96) send_word(OP_REMOVE_ALL, SLOT_W'($urandom), PRIO_W'($urandom));
		else send_word(3'($urandom_range(5, 7)), SLOT_W'($urandom), PRIO_W'($urandom));
	endtask

	// Key extremes, equal keys, moves to head, middle and tail, unused slots, empty list.
	task automatic test_directed;
		send_word(OP_WALK, 6'd0, 8'd0);
		send_word(OP_REMOVE_ALL, 6'd63, 8'd255);
		send_word(OP_ADD, 6'd0, 8'd100);
		send_word(OP_ADD, 6'd63, 8'd255);
		send_word(OP_ADD, 6'd21, 8'd0);
		send_word(OP_ADD, 6'd42, 8'd100);
		send_word(OP_ADD, 6'd0, 8'd100);
		send_word(OP_WALK, 6'd0, 8'd0);
		send_word(OP_SET_PRIO, 6'd1, 8'd255);
		send_word(OP_SET_PRIO, 6'd3, 8'd0);
		send_word(OP_SET_PRIO, 6'd2, 8'd100);
		send_word(OP_WALK, 6'd0, 8'd0);
		send_word(OP_REMOVE, 6'd3, 8'd0);
		send_word(OP_REMOVE, 6'd2, 8'd0);
		send_word(OP_REMOVE, 6'd1, 8'd0);
		send_word(OP_REMOVE, 6'd1, 8'd0);
		send_word(OP_SET_PRIO, 6'd63, 8'd7);
		send_word(OP_ADD, 6'd0, 8'd50);
		send_word(3'd5, 6'd0, 8'd0);
		send_word(3'd7, 6'd63, 8'd255);
		send_word(OP_WALK, 6'd0, 8'd0);
		send_word(OP_REMOVE_ALL, 6'd0, 8'd0);
		send_word(OP_WALK, 6'd0, 8'd0);
		drain();
	endtask

	// Fill the whole pool, overflow it, list it, then free everything.
	task automatic test_pool_full;
		repeat (POOL_SIZE + 2)
			send_word(OP_ADD, SLOT_W'($urandom), PRIO_W'($urandom_range(0, 3) * 85));
		send_word(OP_WALK, 6'd0, 8'd0);
		send_word(OP_REMOVE_ALL, 6'd0, 8'd0);
		send_word(OP_ADD, 6'd0, 8'd9);
		drain();
	endtask

	// With listing off, walk reports nothing to list even after entries are added.
	task automatic test_walk_disabled;
		write_walk_enabled(1'b0);
		repeat (6) send_word(OP_ADD, 6'd0, PRIO_W'($urandom));
		repeat (20) send_random_word();
		send_word(OP_WALK, 6'd0, 8'd0);
		write_walk_enabled(1'b1);
		send_word(OP_WALK, 6'd0, 8'd0);
		drain();
	endtask

	// Hold the receiver off for a long stretch while words keep coming.
	task automatic test_backpressure;
		hold_left = 400;
		repeat (12) send_word(OP_ADD, SLOT_W'($urandom), PRIO_W'($urandom));
		send_word(OP_WALK, 6'd0, 8'd0);
		repeat (8) send_random_word();
		drain();
	endtask

	task automatic test_random(int count);
		repeat (count) send_random_word();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ADD;
		slot = '0;
		priority_req = '0;
		cfg_valid = 1'b0;
		walk_enabled = 1'b1;
		errors = 0;
		words_sent = 0;
		results_seen = 0;
		walks_sent = 0;
		cycles = 0;
		quiet = 1'b0;
		hold_left = 0;
		burst_left = 0;
		taken = 0;
		head = NO_SLOT;
		tail = NO_SLOT;
		listing_on = 1'b1;
		for (int i = 0; i < POOL_SIZE; i++) begin
			key_of[i] = '0;
			next_of[i] = '0;
			prev_of[i] = '0;
			linked[i] = 1'b0;
			spare[i] = SLOT_W'(i);
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pool_full();
		write_walk_enabled(1'b1);
		test_walk_disabled();
		test_backpressure();
		test_random(40);
		write_walk_enabled(1'b0);
		test_random(15);
		write_walk_enabled(1'b1);
		test_random(25);
		// Final stretch runs flat out with no idling on either side.
		quiet = 1'b1;
		test_random(30);
		drain();

		$display("Sent %0d words (%0d walks), checked %0d results across add, remove, move,",
			words_sent, walks_sent, results_seen);
		$display("clear-all, walk on and off, a full pool and a long output hold-off.");
		if (errors == 0 && expected_results.size() == 0) begin
			$display("priority_ordered_slot_list_core_test OK");
		end else begin
			$display("%0d errors, %0d results never arrived", errors, expected_results.size());
			$display("priority_ordered_slot_list_core_test NOT OK");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/posl_pkg.sv
src/posl_cell.sv
src/posl_free_stack.sv
src/priority_ordered_slot_list_core.sv
bench/priority_ordered_slot_list_core_test.sv
